FILE: rtl/core/sspq_pkg.sv
package sspq_pkg;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // input beat
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } in_t;

    // output beat
    typedef struct packed {
        logic signed [31:0] entry_value;
        logic signed [31:0] entry_priority;
        logic [1:0]         status;
        logic               last_of_run;
    } out_t;

    // one stored entry
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] prio;
    } entry_t;

endpackage

FILE: rtl/core/stable_sorted_priority_queue.sv
// Stable sorted priority queue.
// Input channel in_valid/in_ready/in_data carries commands: insert an entry,
// remove the front entry, or list every entry. Output channel
// out_valid/out_ready/out_data carries results; the final beat of each
// command has last_of_run set. Entries leave in ascending priority, equal
// priorities in arrival order.
// Entries sit in a ring-addressed memory with one registered read port and
// one write port; a single comparator walks the ring from the back.
// Insert moves each entry of higher priority up one slot, from the back,
// then writes the new entry. Remove pops the front. List gives one beat
// per entry, front first, reading each after the previous beat is taken.
// Full and empty commands give one status beat; ignored ones give none.
// in_ready is high only while the sequencer is idle, so one command is
// in flight at a time. Results go through an output register: the next
// command is taken while the last beat waits there; if the receiver stalls,
// the sequencer holds its next beat until that register frees.
// Reset empties the queue at once; no clearing pass runs.
module stable_sorted_priority_queue
    import sspq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             res_valid;
    logic             res_ready;
    out_t             res_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;
    logic             out_valid_reg;
    out_t             out_data_reg;

    sspq_seq #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sspq_mem #(
        .DEPTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/sspq_mem.sv
module sspq_mem
    import sspq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/sspq_seq.sv
module sspq_seq
    import sspq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    // command side
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    // result side
    output logic             res_valid,
    input  logic             res_ready,
    output out_t             res_data,
    // store port
    output logic             mem_we,
    output logic [IDX_W-1:0] mem_waddr,
    output entry_t           mem_wdata,
    output logic             mem_re,
    output logic [IDX_W-1:0] mem_raddr,
    input  entry_t           mem_rdata
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_CMP = 4'd2;
    localparam logic [3:0] S_RM_DAT  = 4'd3;
    localparam logic [3:0] S_LS_RD   = 4'd4;
    localparam logic [3:0] S_LS_DAT  = 4'd5;
    localparam logic [3:0] S_LS_EMIT = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]   WRAP_CNT = (CNT_W+1)'(CAPACITY);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    entry_t           new_reg, new_next;
    out_t             res_reg, res_next;

    // logical position to slot index in the ring
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(k);
        if (s >= WRAP_CNT)
        begin
            s = s - WRAP_CNT;
        end
        return s[IDX_W-1:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT) || (state_reg == S_LS_EMIT);
    assign res_data  = res_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        head_next  = head_reg;
        occ_next   = occ_reg;
        new_next   = new_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = phys(head_reg, cur_reg);
        mem_wdata  = new_reg;
        mem_re     = 1'b0;
        mem_raddr  = phys(head_reg, cur_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_next.value = in_data.item_value;
                    new_next.prio  = in_data.item_priority;
                    res_next       = '{entry_value: '0, entry_priority: '0,
                                       status: ST_EMPTY, last_of_run: 1'b1};
                    unique case (in_data.command)
                        CMD_INSERT:
                        begin
                            if (occ_reg == FULL_CNT)
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                cur_next   = occ_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                state_next = S_RM_DAT;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (occ_reg == '0)
                            begin
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cur_next   = '0;
                                state_next = S_LS_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // fetch the neighbor below the hole, or drop the entry at the front
            S_INS_RD:
            begin
                if (cur_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = head_reg;
                    occ_next   = occ_reg + 1'b1;
                    res_next   = '{entry_value: '0, entry_priority: '0,
                                   status: ST_OK, last_of_run: 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = phys(head_reg, cur_reg - 1'b1);
                    state_next = S_INS_CMP;
                end
            end

            // shared compare: move the neighbor up or place the new entry
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (mem_rdata.prio > new_reg.prio)
                begin
                    mem_wdata = mem_rdata;
                    cur_next  = cur_reg - 1'b1;
                    if (cur_reg != CNT_W'(1))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = phys(head_reg, cur_reg - CNT_W'(2));
                    end
                    else
                    begin
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    occ_next   = occ_reg + 1'b1;
                    res_next   = '{entry_value: '0, entry_priority: '0,
                                   status: ST_OK, last_of_run: 1'b1};
                    state_next = S_EMIT;
                end
            end

            // pop the front entry
            S_RM_DAT:
            begin
                res_next   = '{entry_value: mem_rdata.value,
                               entry_priority: mem_rdata.prio,
                               status: ST_OK, last_of_run: 1'b1};
                head_next  = phys(head_reg, CNT_W'(1));
                occ_next   = occ_reg - 1'b1;
                state_next = S_EMIT;
            end

            S_LS_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_LS_DAT;
            end

            S_LS_DAT:
            begin
                res_next   = '{entry_value: mem_rdata.value,
                               entry_priority: mem_rdata.prio,
                               status: ST_OK,
                               last_of_run: (cur_reg + 1'b1 == occ_reg)};
                state_next = S_LS_EMIT;
            end

            S_LS_EMIT:
            begin
                if (res_ready)
                begin
                    if (res_reg.last_of_run)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + 1'b1;
                        state_next = S_LS_RD;
                    end
                end
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            head_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        res_reg <= res_next;
    end

endmodule

FILE: rtl/core/sspq_chk.sv
module sspq_chk
    import sspq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    // no undefined status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status == ST_OK || out_data.status == ST_EMPTY ||
            out_data.status == ST_FULL)
        else $error("bad status code");

    // empty and full results are single zero beats
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.entry_value == '0 && out_data.entry_priority == '0 &&
            out_data.last_of_run)
        else $error("error result carries payload");

    // a real command closes the input once it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command != CMD_NONE |=> !in_ready)
        else $error("command taken while busy");

endmodule

bind stable_sorted_priority_queue sspq_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
